/* rtl/q2e_pkg.sv */
// Shared constants and arctangent table for the quaternion to Euler angle converter
`default_nettype none
package q2e_pkg;

  localparam int unsigned QUAT_W             = 32;
  localparam int unsigned QUAT_FRAC          = 30;
  localparam int unsigned PITCH_W            = 16;
  localparam int unsigned ANGLE_W            = 17;
  localparam int          PITCH_LIMIT        = 23050;
  localparam int          ANGLE_LIMIT        = 46100;
  localparam int unsigned ACC_W              = 34;
  localparam int unsigned TURN_W             = 32;
  localparam int unsigned PROD_W             = 64;
  localparam int unsigned ROUND_SHIFT        = 44;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned CORDIC_STAGES_DEF  = 24;
  localparam int unsigned FRACTION_BITS_DEF  = 30;

  localparam logic signed [PROD_W-1:0] ANGLE_SCALE  = 64'sd377515166;
  localparam logic signed [ACC_W-1:0]  QUARTER_TURN = 34'sd1073741824;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/quaternion_to_euler_angles_top.sv */
// Top level of the quaternion to Euler angle converter
//
//   channel   direction  transfer                 payload
//   command   in         start && !busy           quat_w/x/y/z_i, quat_present_i
//   result    out        valid_o (one cycle)      pitch/roll/yaw_angle_o
//
// One quaternion enters every cycle while busy is low; an absent sample is dropped on entry.
// The pipeline holds the bit-per-stage square root and the unrolled CORDIC stages.
// Reset clears all valid flags; data registers are not reset.
// Results cannot be held off; busy rises only if the inner queue fills.
`default_nettype none
module quaternion_to_euler_angles_top #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRACTION_BITS = q2e_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]     quat_w_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]     quat_x_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]     quat_y_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]     quat_z_i,
  input  wire logic                                  quat_present_i,
  output logic                                       valid_o,
  output logic signed [q2e_pkg::PITCH_W-1:0]         pitch_angle_o,
  output logic signed [q2e_pkg::ANGLE_W-1:0]         roll_angle_o,
  output logic signed [q2e_pkg::ANGLE_W-1:0]         yaw_angle_o
);
  import q2e_pkg::*;

  localparam int unsigned DW = 6 * (FRACTION_BITS + 7);

  logic          take;
  logic          fr_valid, qu_valid, qu_full;
  logic [DW-1:0] fr_data, qu_data;

  assign take = start && !qu_full && quat_present_i;
  assign busy = qu_full;

  q2e_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .quat_w_i(quat_w_i),
    .quat_x_i(quat_x_i),
    .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  q2e_queue #(
    .WIDTH(DW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .data_i (fr_data),
    .full_o (qu_full),
    .valid_o(qu_valid),
    .data_o (qu_data)
  );

  q2e_back #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (qu_valid),
    .data_i       (qu_data),
    .valid_o      (valid_o),
    .pitch_angle_o(pitch_angle_o),
    .roll_angle_o (roll_angle_o),
    .yaw_angle_o  (yaw_angle_o)
  );

endmodule
`default_nettype wire

/* rtl/q2e_front.sv */
// Front end: quaternion products, asin argument and pipelined square root
`default_nettype none
module q2e_front #(
  parameter int unsigned FRACTION_BITS = q2e_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       take_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]          quat_w_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]          quat_x_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]          quat_y_i,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0]          quat_z_i,
  output logic                                            valid_o,
  output logic [6*(FRACTION_BITS+7)-1:0]                  data_o
);
  import q2e_pkg::*;

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned PW  = F + 4;
  localparam int unsigned IW  = F + 7;
  localparam int unsigned SW  = F + 2;
  localparam int unsigned NW  = 2 * F + 1;
  localparam int unsigned RW  = 2 * F + 4;
  localparam int unsigned RB  = F + 1;
  localparam int unsigned SD  = SW + 4 * IW;
  localparam int unsigned SH  = QUAT_FRAC - F;
  localparam logic signed [IW-1:0] ONE = IW'(64'sd1 <<< F);
  localparam logic signed [IW-1:0] MONE = -ONE;

  logic                       v0_q, v1_q, v2_q;
  logic signed [QUAT_W-1:0]   w_q, x_q, y_q, z_q;
  logic signed [PW-1:0]       wy_q, xz_q, yz_q, wx_q, xx_q, yy_q, xy_q, wz_q, ww_q, zz_q;
  logic signed [PW-1:0]       wy_d, xz_d, yz_d, wx_d, xx_d, yy_d, xy_d, wz_d, ww_d, zz_d;
  logic signed [IW-1:0]       s_full, ry_d, rx_d, ya_d, yx_d;
  logic signed [SW-1:0]       s_d, s_q;
  logic signed [IW-1:0]       ry_q, rx_q, ya_q, yx_q;
  logic signed [PROD_W-1:0]   sq;
  logic [NW-1:0]              n_d;
  logic [RW-1:0]              rem_q  [0:RB];
  logic [RB-1:0]              root_q [0:RB];
  logic [SD-1:0]              sd_q   [0:RB];
  logic                       sv_q   [0:RB];

  function automatic logic signed [PW-1:0] mulq(input logic signed [QUAT_W-1:0] a,
                                                input logic signed [QUAT_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return PW'(p >>> F);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= take_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= quat_w_i >>> SH;
    x_q <= quat_x_i >>> SH;
    y_q <= quat_y_i >>> SH;
    z_q <= quat_z_i >>> SH;
  end

  always_comb begin
    wy_d = mulq(w_q, y_q);
    xz_d = mulq(x_q, z_q);
    yz_d = mulq(y_q, z_q);
    wx_d = mulq(w_q, x_q);
    xx_d = mulq(x_q, x_q);
    yy_d = mulq(y_q, y_q);
    xy_d = mulq(x_q, y_q);
    wz_d = mulq(w_q, z_q);
    ww_d = mulq(w_q, w_q);
    zz_d = mulq(z_q, z_q);
  end

  always_ff @(posedge clk_i) begin
    wy_q <= wy_d;
    xz_q <= xz_d;
    yz_q <= yz_d;
    wx_q <= wx_d;
    xx_q <= xx_d;
    yy_q <= yy_d;
    xy_q <= xy_d;
    wz_q <= wz_d;
    ww_q <= ww_d;
    zz_q <= zz_d;
  end

  always_comb begin
    s_full = (IW'(wy_q) - IW'(xz_q)) <<< 1;
    if (s_full > ONE) begin
      s_d = SW'(ONE);
    end else if (s_full < MONE) begin
      s_d = SW'(MONE);
    end else begin
      s_d = SW'(s_full);
    end
    ry_d = (IW'(yz_q) + IW'(wx_q)) <<< 1;
    rx_d = ONE - ((IW'(xx_q) + IW'(yy_q)) <<< 1);
    ya_d = (IW'(xy_q) + IW'(wz_q)) <<< 1;
    yx_d = IW'(ww_q) + IW'(xx_q) - IW'(yy_q) - IW'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    ry_q <= ry_d;
    rx_q <= rx_d;
    ya_q <= ya_d;
    yx_q <= yx_d;
  end

  always_comb begin
    sq  = PROD_W'(s_q) * PROD_W'(s_q);
    n_d = NW'((64'sd1 <<< (2 * F)) - sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else begin
      sv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(n_d);
    root_q[0] <= '0;
    sd_q[0]   <= {s_q, ry_q, rx_q, ya_q, yx_q};
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int unsigned K = RB - 1 - j;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d;
    logic [RB-1:0] root_d;

    always_comb begin
      trial  = (RW'(root_q[j]) << (K + 1)) + (RW'(1) << (2 * K));
      rem_d  = rem_q[j];
      root_d = root_q[j];
      if (rem_q[j] >= trial) begin
        rem_d  = rem_q[j] - trial;
        root_d = root_q[j] | (RB'(1) << K);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_d;
      root_q[j+1] <= root_d;
      sd_q[j+1]   <= sd_q[j];
    end
  end

  logic signed [SW-1:0] s_o;
  logic signed [IW-1:0] ry_o, rx_o, ya_o, yx_o;

  assign {s_o, ry_o, rx_o, ya_o, yx_o} = sd_q[RB];
  assign valid_o = sv_q[RB];
  assign data_o  = {IW'(s_o), IW'(root_q[RB]), ry_o, rx_o, ya_o, yx_o};

endmodule
`default_nettype wire

/* rtl/q2e_queue.sv */
// Short queue between front and back ends
`default_nettype none
module q2e_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);
  import q2e_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign pop = (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= pop;
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
    if (pop) begin
      data_q <= mem[rd_q];
    end
  end

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/q2e_cordic.sv */
// Pipelined vectoring CORDIC with scaling to 1/256 degree and clamp
`default_nettype none
module q2e_cordic #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRACTION_BITS = q2e_pkg::FRACTION_BITS_DEF,
  parameter int unsigned OUT_W         = q2e_pkg::ANGLE_W,
  parameter int          LIMIT         = q2e_pkg::ANGLE_LIMIT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [FRACTION_BITS+6:0]   y_i,
  input  wire logic signed [FRACTION_BITS+6:0]   x_i,
  output logic                                   valid_o,
  output logic signed [OUT_W-1:0]                angle_o
);
  import q2e_pkg::*;

  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned XW = FRACTION_BITS + 10;
  localparam logic signed [PROD_W-1:0] HI   = PROD_W'(LIMIT);
  localparam logic signed [PROD_W-1:0] LO   = -HI;
  localparam logic signed [PROD_W-1:0] HALF = 64'sd1 <<< (ROUND_SHIFT - 1);

  logic signed [XW-1:0]    x_q [0:N];
  logic signed [XW-1:0]    y_q [0:N];
  logic signed [ACC_W-1:0] a_q [0:N];
  logic                    z_q [0:N];
  logic                    v_q [0:N];

  logic signed [XW-1:0]    x0_d, y0_d, xe, ye;
  logic signed [ACC_W-1:0] a0_d;

  always_comb begin
    xe   = XW'(x_i);
    ye   = XW'(y_i);
    x0_d = xe;
    y0_d = ye;
    a0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        a0_d = QUARTER_TURN;
      end else begin
        x0_d = -ye;
        y0_d = xe;
        a0_d = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x0_d;
    y_q[0] <= y0_d;
    a_q[0] <= a0_d;
    z_q[0] <= (x_i == '0) && (y_i == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0]    dx, dy;
    logic signed [ACC_W-1:0] at;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign at = ACC_W'(atan_turn(5'(i)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      z_q[i+1] <= z_q[i];
      if (!y_q[i][XW-1]) begin
        x_q[i+1] <= x_q[i] + dy;
        y_q[i+1] <= y_q[i] - dx;
        a_q[i+1] <= a_q[i] + at;
      end else begin
        x_q[i+1] <= x_q[i] - dy;
        y_q[i+1] <= y_q[i] + dx;
        a_q[i+1] <= a_q[i] - at;
      end
    end
  end

  logic                     pv_q, ov_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, r;
  logic signed [OUT_W-1:0]  angle_q, angle_d;

  assign prod_d = z_q[N] ? '0 : PROD_W'(a_q[N]) * ANGLE_SCALE;

  always_comb begin
    r = (prod_q + HALF) >>> ROUND_SHIFT;
    if (r > HI) begin
      r = HI;
    end else if (r < LO) begin
      r = LO;
    end
    angle_d = OUT_W'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      pv_q <= v_q[N];
      ov_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    angle_q <= angle_d;
  end

  assign valid_o = ov_q;
  assign angle_o = angle_q;

endmodule
`default_nettype wire

/* rtl/q2e_back.sv */
// Back end: three CORDIC pipelines for pitch, roll and yaw
`default_nettype none
module q2e_back #(
  parameter int unsigned CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRACTION_BITS = q2e_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  input  wire logic [6*(FRACTION_BITS+7)-1:0]        data_i,
  output logic                                       valid_o,
  output logic signed [q2e_pkg::PITCH_W-1:0]         pitch_angle_o,
  output logic signed [q2e_pkg::ANGLE_W-1:0]         roll_angle_o,
  output logic signed [q2e_pkg::ANGLE_W-1:0]         yaw_angle_o
);
  import q2e_pkg::*;

  localparam int unsigned IW = FRACTION_BITS + 7;

  logic signed [IW-1:0] s, c, ry, rx, ya, yx;

  assign {s, c, ry, rx, ya, yx} = data_i;

  q2e_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS),
    .OUT_W        (PITCH_W),
    .LIMIT        (PITCH_LIMIT)
  ) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .y_i    (s),
    .x_i    (c),
    .valid_o(valid_o),
    .angle_o(pitch_angle_o)
  );

  q2e_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS),
    .OUT_W        (ANGLE_W),
    .LIMIT        (ANGLE_LIMIT)
  ) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .y_i    (ry),
    .x_i    (rx),
    .valid_o(),
    .angle_o(roll_angle_o)
  );

  q2e_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS),
    .OUT_W        (ANGLE_W),
    .LIMIT        (ANGLE_LIMIT)
  ) u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .y_i    (ya),
    .x_i    (yx),
    .valid_o(),
    .angle_o(yaw_angle_o)
  );

endmodule
`default_nettype wire
